/* rtl/bangle_pkg.sv */
// bangle_pkg: shared types and constants for the binary angle atan2 pipeline.
// No dependencies.
package bangle_pkg;

    localparam int Q_WIDTH     = 17;
    localparam int G_WIDTH     = 15;
    localparam int K_WIDTH     = 15;
    localparam int CORR_WIDTH  = 14;
    localparam int OCT_WIDTH   = 8;
    localparam int ANGLE_WIDTH = 10;

    localparam logic [Q_WIDTH-1:0]     T_ONE      = 17'h10000;
    localparam logic [K_WIDTH-1:0]     K_BASE     = 15'd16036;
    localparam logic [12:0]            K_SLOPE    = 13'd4345;
    localparam logic [7:0]             CORR_GAIN  = 8'd163;
    localparam logic [ANGLE_WIDTH-1:0] ANG_QUART  = 10'd256;
    localparam logic [ANGLE_WIDTH-1:0] ANG_HALF   = 10'd512;
    localparam logic [ANGLE_WIDTH-1:0] ANG_ZERO   = 10'd0;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic swap;
        logic zero;
    } bangle_meta_t;

endpackage

/* rtl/bangle_fold.sv */
// bangle_fold: magnitudes, signs and ordering of the input vector; one register stage.
// Depends on bangle_pkg.
module bangle_fold #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_WIDTH-1:0] vec_x,
    input  logic signed [COORD_WIDTH-1:0] vec_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [COORD_WIDTH-1:0]       out_small,
    output logic [COORD_WIDTH-1:0]       out_large,
    output bangle_pkg::bangle_meta_t     out_meta
);

    logic                     valid_reg;
    logic [COORD_WIDTH-1:0]   small_reg;
    logic [COORD_WIDTH-1:0]   large_reg;
    bangle_pkg::bangle_meta_t meta_reg;

    logic [COORD_WIDTH-1:0]   mag_x;
    logic [COORD_WIDTH-1:0]   mag_y;
    logic                     swap;

    assign mag_x = vec_x[COORD_WIDTH-1] ? (~vec_x + 1'b1) : vec_x;
    assign mag_y = vec_y[COORD_WIDTH-1] ? (~vec_y + 1'b1) : vec_y;
    assign swap  = mag_y > mag_x;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            small_reg     <= swap ? mag_x : mag_y;
            large_reg     <= swap ? mag_y : mag_x;
            meta_reg.xneg <= vec_x[COORD_WIDTH-1];
            meta_reg.yneg <= vec_y[COORD_WIDTH-1];
            meta_reg.swap <= swap;
            meta_reg.zero <= (mag_x == '0) && (mag_y == '0);
        end
    end

    assign out_valid = valid_reg;
    assign out_small = small_reg;
    assign out_large = large_reg;
    assign out_meta  = meta_reg;

endmodule

/* rtl/bangle_div.sv */
// bangle_div: pipelined restoring divider, one quotient bit per stage, t = small*2^16/large.
// Depends on bangle_pkg.
module bangle_div #(
    parameter int MAG_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [MAG_WIDTH-1:0]          in_small,
    input  logic [MAG_WIDTH-1:0]          in_large,
    input  bangle_pkg::bangle_meta_t      in_meta,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bangle_pkg::Q_WIDTH-1:0] out_t,
    output bangle_pkg::bangle_meta_t      out_meta
);

    localparam int STEPS = bangle_pkg::Q_WIDTH;

    logic                           valid_reg [STEPS];
    logic [MAG_WIDTH-1:0]           rem_reg   [STEPS];
    logic [MAG_WIDTH-1:0]           large_reg [STEPS];
    logic [STEPS-1:0]               q_reg     [STEPS];
    bangle_pkg::bangle_meta_t       meta_reg  [STEPS];
    logic                           stg_ready [STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_step
            logic                     stg_valid;
            logic [MAG_WIDTH-1:0]     stg_rem;
            logic [MAG_WIDTH-1:0]     stg_large;
            logic [STEPS-1:0]         stg_q;
            bangle_pkg::bangle_meta_t stg_meta;
            logic [MAG_WIDTH:0]       trial;
            logic                     qbit;
            logic [MAG_WIDTH:0]       diff;
            logic                     down_ready;

            if (i == 0) begin : g_first
                assign stg_valid = in_valid;
                assign stg_rem   = in_small;
                assign stg_large = in_large;
                assign stg_q     = '0;
                assign stg_meta  = in_meta;
                assign trial     = {1'b0, stg_rem};
            end else begin : g_rest
                assign stg_valid = valid_reg[i-1];
                assign stg_rem   = rem_reg[i-1];
                assign stg_large = large_reg[i-1];
                assign stg_q     = q_reg[i-1];
                assign stg_meta  = meta_reg[i-1];
                assign trial     = {stg_rem, 1'b0};
            end

            if (i == STEPS-1) begin : g_last
                assign down_ready = out_ready;
            end else begin : g_mid
                assign down_ready = stg_ready[i+1];
            end

            assign diff = trial - {1'b0, stg_large};
            assign qbit = trial >= {1'b0, stg_large};
            assign stg_ready[i] = !valid_reg[i] || down_ready;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[i] <= 1'b0;
                end else if (stg_ready[i]) begin
                    valid_reg[i] <= stg_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (stg_ready[i] && stg_valid) begin
                    rem_reg[i]   <= qbit ? diff[MAG_WIDTH-1:0] : trial[MAG_WIDTH-1:0];
                    large_reg[i] <= stg_large;
                    q_reg[i]     <= {stg_q[STEPS-2:0], qbit};
                    meta_reg[i]  <= stg_meta;
                end
            end
        end
    endgenerate

    assign in_ready  = stg_ready[0];
    assign out_valid = valid_reg[STEPS-1];
    assign out_t     = q_reg[STEPS-1];
    assign out_meta  = meta_reg[STEPS-1];

endmodule

/* rtl/bangle_poly.sv */
// bangle_poly: Q16 polynomial octant arctangent and unfolding, four register stages.
// Depends on bangle_pkg.
module bangle_poly (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bangle_pkg::Q_WIDTH-1:0]       in_t,
    input  bangle_pkg::bangle_meta_t             in_meta,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [bangle_pkg::ANGLE_WIDTH-1:0]   m_angle
);

    localparam int QW = bangle_pkg::Q_WIDTH;
    localparam int AW = bangle_pkg::ANGLE_WIDTH;

    logic                                valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg;
    logic                                ready_a, ready_b, ready_c, ready_d;

    logic [QW-1:0]                       t_a_reg, t_b_reg;
    logic [bangle_pkg::G_WIDTH-1:0]      g_a_reg;
    logic [bangle_pkg::K_WIDTH-1:0]      k_a_reg;
    logic [bangle_pkg::CORR_WIDTH-1:0]   corr_b_reg;
    logic [bangle_pkg::OCT_WIDTH-1:0]    u_c_reg;
    logic [AW-1:0]                       angle_reg;
    bangle_pkg::bangle_meta_t            meta_a_reg, meta_b_reg, meta_c_reg;

    logic [2*QW-1:0]                     prod_g;
    logic [29:0]                         prod_k;
    logic [29:0]                         prod_c;
    logic [23:0]                         sum_u;
    logic [AW-1:0]                       a0, a1, a2;

    assign ready_d  = !valid_d_reg || m_ready;
    assign ready_c  = !valid_c_reg || ready_d;
    assign ready_b  = !valid_b_reg || ready_c;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    assign prod_g = (2*QW)'(in_t) * (2*QW)'(bangle_pkg::T_ONE - in_t);
    assign prod_k = 30'(bangle_pkg::K_SLOPE) * 30'(in_t);
    assign prod_c = 30'(g_a_reg) * 30'(k_a_reg);
    assign sum_u  = (24'(t_b_reg) << 7) + 24'(bangle_pkg::CORR_GAIN) * 24'(corr_b_reg);

    assign a0 = meta_c_reg.swap ? (bangle_pkg::ANG_QUART - AW'(u_c_reg)) : AW'(u_c_reg);
    assign a1 = meta_c_reg.xneg ? (bangle_pkg::ANG_HALF - a0) : a0;
    assign a2 = meta_c_reg.yneg ? (bangle_pkg::ANG_ZERO - a1) : a1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                valid_a_reg <= in_valid;
            end
            if (ready_b) begin
                valid_b_reg <= valid_a_reg;
            end
            if (ready_c) begin
                valid_c_reg <= valid_b_reg;
            end
            if (ready_d) begin
                valid_d_reg <= valid_c_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a && in_valid) begin
            t_a_reg    <= in_t;
            g_a_reg    <= prod_g[16 +: bangle_pkg::G_WIDTH];
            k_a_reg    <= bangle_pkg::K_BASE + bangle_pkg::K_WIDTH'(prod_k[29:16]);
            meta_a_reg <= in_meta;
        end
        if (ready_b && valid_a_reg) begin
            t_b_reg    <= t_a_reg;
            corr_b_reg <= prod_c[16 +: bangle_pkg::CORR_WIDTH];
            meta_b_reg <= meta_a_reg;
        end
        if (ready_c && valid_b_reg) begin
            u_c_reg    <= sum_u[23:16];
            meta_c_reg <= meta_b_reg;
        end
        if (ready_d && valid_c_reg) begin
            angle_reg  <= meta_c_reg.zero ? bangle_pkg::ANG_ZERO : a2;
        end
    end

    assign m_valid = valid_d_reg;
    assign m_angle = angle_reg;

endmodule

/* rtl/binary_angle_atan2.sv */
// binary_angle_atan2: top level, angle of a signed vector at 1024 units per turn.
// Depends on bangle_pkg, bangle_fold, bangle_div, bangle_poly.
//
//   channel  ports                      dir  payload
//   s_       s_valid s_ready            in   s_vec_x, s_vec_y (COORD_WIDTH, signed)
//   m_       m_valid m_ready            out  m_angle (10 bits, unsigned)
//
// One transfer per cycle while m_ready is high; fold, divider, polynomial in turn.
// Every stage has its own valid bit; ready of a stage is empty-or-downstream-ready,
// so bubbles close up and a stall holds each item in place.
// Synchronous active-low reset clears the valid bits only.
module binary_angle_atan2 #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_vec_x,
    input  logic signed [COORD_WIDTH-1:0] s_vec_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [9:0]                    m_angle
);

    logic                                 fold_valid, fold_ready;
    logic [COORD_WIDTH-1:0]               fold_small, fold_large;
    bangle_pkg::bangle_meta_t             fold_meta;
    logic                                 div_valid, div_ready;
    logic [bangle_pkg::Q_WIDTH-1:0]       div_t;
    bangle_pkg::bangle_meta_t             div_meta;

    bangle_fold #(.COORD_WIDTH(COORD_WIDTH)) u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .vec_x     (s_vec_x),
        .vec_y     (s_vec_y),
        .out_valid (fold_valid),
        .out_ready (fold_ready),
        .out_small (fold_small),
        .out_large (fold_large),
        .out_meta  (fold_meta)
    );

    bangle_div #(.MAG_WIDTH(COORD_WIDTH)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fold_valid),
        .in_ready  (fold_ready),
        .in_small  (fold_small),
        .in_large  (fold_large),
        .in_meta   (fold_meta),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_t     (div_t),
        .out_meta  (div_meta)
    );

    bangle_poly u_poly (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (div_valid),
        .in_ready (div_ready),
        .in_t     (div_t),
        .in_meta  (div_meta),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_angle  (m_angle)
    );

endmodule

/* verif/binary_angle_atan2_checker.sv */
// binary_angle_atan2_checker: watches both channels, predicts each angle and compares.
// Depends on bangle_pkg; instantiated beside the block by binary_angle_atan2_tb.
`timescale 1ns / 100ps

module binary_angle_atan2_checker #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_vec_x,
    input  logic signed [COORD_WIDTH-1:0] s_vec_y,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [9:0]                    m_angle,
    output int                            fail_count,
    output int                            pending
);

    logic [bangle_pkg::ANGLE_WIDTH-1:0] angle_q[$];

    function automatic logic [bangle_pkg::ANGLE_WIDTH-1:0] octant_angle(longint unsigned t);
        longint unsigned g, k, corr;
        g    = (t * (64'd65536 - t)) / 64'd65536;
        k    = 64'd16036 + (64'd4345 * t) / 64'd65536;
        corr = (g * k) / 64'd65536;
        return bangle_pkg::ANGLE_WIDTH'((64'd128 * t + 64'd163 * corr) / 64'd65536);
    endfunction

    function automatic logic [bangle_pkg::ANGLE_WIDTH-1:0] vector_angle(
        logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y);
        longint unsigned mx, my;
        logic [bangle_pkg::ANGLE_WIDTH-1:0] a;
        mx = x[COORD_WIDTH-1] ? (64'd1 << COORD_WIDTH) - 64'(x) : 64'(x);
        my = y[COORD_WIDTH-1] ? (64'd1 << COORD_WIDTH) - 64'(y) : 64'(y);
        if (mx == 0 && my == 0) return bangle_pkg::ANG_ZERO;
        if (my <= mx) a = octant_angle((my << 16) / mx);
        else          a = bangle_pkg::ANG_QUART - octant_angle((mx << 16) / my);
        if (x[COORD_WIDTH-1]) a = bangle_pkg::ANG_HALF - a;
        if (y[COORD_WIDTH-1]) a = bangle_pkg::ANG_ZERO - a;
        return a;
    endfunction

    assign pending = angle_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) angle_q.push_back(vector_angle(s_vec_x, s_vec_y));
            if (m_valid && m_ready) begin
                if (angle_q.size() == 0) begin
                    $error("unexpected angle transfer: %0d", m_angle);
                    fail_count <= fail_count + 1;
                end else if (angle_q[0] !== m_angle) begin
                    $error("angle: expected %0d, actual %0d", angle_q[0], m_angle);
                    fail_count <= fail_count + 1;
                    void'(angle_q.pop_front());
                end else begin
                    void'(angle_q.pop_front());
                end
            end
        end
    end
endmodule

/* verif/binary_angle_atan2_tb.sv */
// binary_angle_atan2_tb: stimulus and verdict for binary_angle_atan2.
// Depends on bangle_pkg, the RTL and binary_angle_atan2_checker.
`timescale 1ns / 100ps

module binary_angle_atan2_tb;
    localparam int CW = 32;
    localparam int N_RANDOM = 1800;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [CW-1:0] s_vec_x = '0;
    logic signed [CW-1:0] s_vec_y = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [9:0]           m_angle;
    int                   fail_count;
    int                   pending;
    bit                   hold_off = 1'b0;

    logic signed [CW-1:0] dir_x[$];
    logic signed [CW-1:0] dir_y[$];

    binary_angle_atan2 #(.COORD_WIDTH(CW)) uut (.*);

    binary_angle_atan2_checker #(.COORD_WIDTH(CW)) chk (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver stall pattern, with one long hold-off of m_ready
    initial begin
        int mode;
        bit held_done;
        mode = 0;
        held_done = 1'b0;
        while (1) begin
            @(negedge aclk);
            if (hold_off && !held_done) begin
                m_ready <= 1'b0;
                repeat (200) @(negedge aclk);
                held_done = 1'b1;
            end
            mode = ($urandom_range(0, 199) < 1) ? 0 : mode;
            if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_vector(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        s_valid <= 1'b1;
        s_vec_x <= x;
        s_vec_y <= y;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 40) - 20;
            1: return $signed($urandom) >>> $urandom_range(0, CW - 1);
            2: return {1'b1, {(CW-1){1'b0}}} + $urandom_range(0, 3);
            3: return {1'b0, {(CW-1){1'b1}}} - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic signed [CW-1:0] mn, mx, x, y;
        int burst, cnt;
        mn = {1'b1, {(CW-1){1'b0}}};
        mx = {1'b0, {(CW-1){1'b1}}};
        dir_x = '{0, 1, 0, -1, 0, 5, -5, -5, 5, mx, mn, mn, mx, mn, 0, mn, 1, mx, -1,
                  3, 7, -1, mx, mn};
        dir_y = '{0, 0, 1, 0, -1, 5, 5, -5, -5, mx, mn, mx, mn, 0, mn, 1, mn, 1, mx,
                  7, 3, -1, mn, mx};
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (dir_x[i]) send_vector(dir_x[i], dir_y[i]);
        cnt = 0;
        while (cnt < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                if (cnt == 300) hold_off = 1'b1;
                x = rand_coord();
                y = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? x : -x)
                                                 : rand_coord();
                send_vector(x, y);
                cnt++;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* binary_angle_atan2.f */
rtl/bangle_pkg.sv
rtl/bangle_fold.sv
rtl/bangle_div.sv
rtl/bangle_poly.sv
rtl/binary_angle_atan2.sv
verif/binary_angle_atan2_checker.sv
verif/binary_angle_atan2_tb.sv
